FILE: rtl/purqp_pkg.sv
`timescale 1ns / 1ps

package purqp_pkg;

	// Default pool size and unit count.
	localparam int PURQP_NODES = 128;
	localparam int PURQP_UNITS = 4;

	// Stream widths: payload fields packed from bit 0, padded to whole bytes.
	localparam int S_DATA_W = 208;
	localparam int M_DATA_W = 208;

	// Operation codes carried on the input selector.
	typedef enum logic [1:0] {
		OP_SUBMIT  = 2'd0,
		OP_POP     = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BUSY        = 3'd1,
		ST_BAD_UNIT    = 3'd2,
		ST_EMPTY       = 3'd3,
		ST_BAD_RELEASE = 3'd4
	} status_t;

	// One input item as held in the input register.
	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  unit;
		logic [63:0] byte_offset;
		logic [63:0] list_address;
		logic [31:0] sector_count;
		logic        is_write;
		logic [31:0] request_tag;
		logic [6:0]  node_index;
	} item_t;

	// One result item.
	typedef struct packed {
		status_t     status;
		logic [6:0]  node;
		logic [1:0]  unit;
		logic [63:0] offset;
		logic [63:0] list_address;
		logic [31:0] count;
		logic        write;
		logic [31:0] tag;
	} result_t;

	// Request fields stored per node.
	typedef struct packed {
		logic [63:0] offset;
		logic [63:0] address;
		logic [31:0] count;
		logic [31:0] tag;
		logic [1:0]  unit;
		logic        write;
	} slot_t;

	// Handshake control from the top level to the queue core.
	typedef struct packed {
		logic       accept;
		logic       fire;
		logic [1:0] op;
		logic [2:0] unit;
	} ctl_t;

endpackage

FILE: rtl/purqp_ram.sv
`timescale 1ns / 1ps

module purqp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read returning the old data on a collision.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/purqp_core.sv
`timescale 1ns / 1ps

module purqp_core
	import purqp_pkg::*;
#(
	parameter int NODES = PURQP_NODES,
	parameter int UNITS = PURQP_UNITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  ctl_t    ctl,
	input  item_t   item,
	output result_t result
);

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW = NW + 1;
	localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam logic [LW-1:0] LNULL = {1'b1, {NW{1'b0}}};
	localparam logic [LW-1:0] LTOP = LW'(NODES - 1);

	// List state: the top bit of a link marks null.
	logic [LW-1:0]    free_top_q, free_top_d;
	logic [LW-1:0]    first_q [UNITS];
	logic [LW-1:0]    first_d [UNITS];
	logic [LW-1:0]    last_q [UNITS];
	logic [LW-1:0]    last_d [UNITS];
	logic [NODES-1:0] held_q;
	logic [NODES-1:0] lvalid_q;

	// Read side of the memories and same-cycle write bypass.
	logic [LW-1:0] rd_addr_q, rd_addr_d;
	logic [NW-1:0] rd_idx, rd_idx_d;
	logic          lv_q;
	logic          lbyp_q, sbyp_q;
	logic [LW-1:0] lbyp_data_q;
	slot_t         sbyp_data_q;
	logic [LW-1:0] link_rdata, link_dflt, link_rd;
	logic [$bits(slot_t)-1:0] slot_rdata;
	slot_t         slot_rd;

	// Write requests from the compute stage.
	logic          link_we, slot_we, held_we, held_val;
	logic [NW-1:0] link_waddr, slot_waddr, held_idx;
	logic [LW-1:0] link_wdata;
	slot_t         slot_wdata;

	// Decoded item fields.
	logic          u_ok, idx_ok, in_u_ok;
	logic [UW-1:0] u, in_u;
	logic [NW-1:0] idx, top_n, head_n;

	assign u_ok    = 32'(item.unit) < 32'(UNITS);
	assign u       = u_ok ? UW'(item.unit) : '0;
	assign idx_ok  = 32'(item.node_index) < 32'(NODES);
	assign idx     = NW'(item.node_index);
	assign top_n   = free_top_q[NW-1:0];
	assign head_n  = first_q[u][NW-1:0];
	assign in_u_ok = 32'(ctl.unit) < 32'(UNITS);
	assign in_u    = in_u_ok ? UW'(ctl.unit) : '0;

	// An unwritten link still holds its reset chain: node i points to i-1.
	assign rd_idx    = rd_addr_q[NW-1:0];
	assign link_dflt = (rd_idx == '0) ? LNULL : {1'b0, rd_idx - NW'(1)};
	assign link_rd   = lbyp_q ? lbyp_data_q : (lv_q ? link_rdata : link_dflt);
	assign slot_rd   = sbyp_q ? sbyp_data_q : slot_t'(slot_rdata);

	// One operation on the lists, applied when the item leaves the input register.
	always_comb begin
		free_top_d = free_top_q;
		first_d    = first_q;
		last_d     = last_q;
		link_we    = 1'b0;
		link_waddr = '0;
		link_wdata = '0;
		slot_we    = 1'b0;
		slot_waddr = top_n;
		slot_wdata = '{offset: item.byte_offset, address: item.list_address,
			count: item.sector_count, tag: item.request_tag,
			unit: item.unit[1:0], write: item.is_write};
		held_we    = 1'b0;
		held_val   = 1'b0;
		held_idx   = '0;
		result     = '0;
		if (ctl.fire) begin
			case (op_t'(item.op))
				OP_SUBMIT: begin
					if (!u_ok) begin
						result.status = ST_BAD_UNIT;
					end else if (free_top_q[NW]) begin
						result.status = ST_BUSY;
					end else begin
						free_top_d = link_rd;
						slot_we    = 1'b1;
						held_we    = 1'b1;
						held_idx   = top_n;
						// Append behind the tail, or start an empty queue.
						if (!last_q[u][NW]) begin
							link_we    = 1'b1;
							link_waddr = last_q[u][NW-1:0];
							link_wdata = {1'b0, top_n};
						end else begin
							first_d[u] = {1'b0, top_n};
						end
						last_d[u]     = {1'b0, top_n};
						result.status = ST_OK;
						result.node   = 7'(top_n);
					end
				end
				OP_POP: begin
					if (!u_ok) begin
						result.status = ST_BAD_UNIT;
					end else if (first_q[u][NW]) begin
						result.status = ST_EMPTY;
					end else begin
						// The tail's link is stale; the queue simply empties there.
						if (first_q[u] == last_q[u]) begin
							first_d[u] = LNULL;
							last_d[u]  = LNULL;
						end else begin
							first_d[u] = link_rd;
						end
						held_we             = 1'b1;
						held_val            = 1'b1;
						held_idx            = head_n;
						result.status       = ST_OK;
						result.node         = 7'(head_n);
						result.unit         = slot_rd.unit;
						result.offset       = slot_rd.offset;
						result.list_address = slot_rd.address;
						result.count        = slot_rd.count;
						result.write        = slot_rd.write;
						result.tag          = slot_rd.tag;
					end
				end
				OP_RELEASE: begin
					result.node = item.node_index;
					if (idx_ok && held_q[idx]) begin
						held_we       = 1'b1;
						held_idx      = idx;
						link_we       = 1'b1;
						link_waddr    = idx;
						link_wdata    = free_top_q;
						free_top_d    = {1'b0, idx};
						result.status = ST_OK;
					end else begin
						result.status = ST_BAD_RELEASE;
					end
				end
				default: begin
					result = '0;
				end
			endcase
		end
	end

	// Read address for the next item, taken from the updated heads; a stalled
	// item re-reads its own address.
	always_comb begin
		if (!ctl.accept) begin
			rd_addr_d = rd_addr_q;
		end else if (op_t'(ctl.op) == OP_SUBMIT) begin
			rd_addr_d = free_top_d;
		end else begin
			rd_addr_d = first_d[in_u];
		end
	end
	assign rd_idx_d = rd_addr_d[NW-1:0];

	// List state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q <= LTOP;
			first_q    <= '{default: LNULL};
			last_q     <= '{default: LNULL};
			held_q     <= '0;
			lvalid_q   <= '0;
		end else begin
			free_top_q <= free_top_d;
			first_q    <= first_d;
			last_q     <= last_d;
			if (held_we) begin
				held_q[held_idx] <= held_val;
			end
			if (link_we) begin
				lvalid_q[link_waddr] <= 1'b1;
			end
		end
	end

	// Read tracking and bypass of a write that lands on the address being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= LNULL;
			lv_q      <= 1'b0;
			lbyp_q    <= 1'b0;
			sbyp_q    <= 1'b0;
		end else begin
			rd_addr_q <= rd_addr_d;
			lv_q      <= lvalid_q[rd_idx_d];
			lbyp_q    <= link_we && (link_waddr == rd_idx_d);
			sbyp_q    <= slot_we && (slot_waddr == rd_idx_d);
		end
	end

	always_ff @(posedge clk) begin
		lbyp_data_q <= link_wdata;
		sbyp_data_q <= slot_wdata;
	end

	// Link store.
	purqp_ram #(
		.WIDTH(LW),
		.DEPTH(NODES)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(rd_idx_d),
		.rdata(link_rdata)
	);

	// Request fields per node.
	purqp_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(NODES)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(rd_idx_d),
		.rdata(slot_rdata)
	);

endmodule

FILE: rtl/per_unit_request_queue_pool_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Content
// s_        in   s_tvalid/s_tready  one operation: submit, pop or release
// m_        out  m_tvalid/m_tready  one result per operation
//
// One item is accepted per cycle while the output side takes results. Its result
// passes the input register and then the output register: the accepting edge loads the
// input register and reads the link and slot memories, and the output register loads
// as the item moves on. The next item's memory read is addressed from the heads updated
// by the current item, with a bypass for a write that lands on the same address.
// Reset is asynchronous; the free chain comes from per-node valid flags, so
// no clearing pass is needed. Once the output register holds a result, a low m_tready
// holds both registers and drops s_tready while the input register holds an item.

module per_unit_request_queue_pool_top
	import purqp_pkg::*;
#(
	parameter int NODES = PURQP_NODES,
	parameter int UNITS = PURQP_UNITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// unit, byte_offset, list_address, sector_count, is_write, request_tag, node_index
	input  logic [S_DATA_W-1:0] s_tdata,
	// op
	input  logic [1:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// out_node, out_unit, out_offset, out_list_address, out_count, out_write, out_tag
	output logic [M_DATA_W-1:0] m_tdata,
	// status
	output logic [2:0]          m_tuser
);

	item_t   item_in, item_s1;
	result_t result, result_q;
	ctl_t    ctl;
	logic    s1_valid_q;
	logic    out_valid_q;
	logic    accept, fire;

	// Unpack the input item.
	always_comb begin
		item_in.op           = s_tuser;
		item_in.unit         = s_tdata[2:0];
		item_in.byte_offset  = s_tdata[66:3];
		item_in.list_address = s_tdata[130:67];
		item_in.sector_count = s_tdata[162:131];
		item_in.is_write     = s_tdata[163];
		item_in.request_tag  = s_tdata[195:164];
		item_in.node_index   = s_tdata[202:196];
	end

	// The input register moves on whenever the output register can take a result.
	assign fire     = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || fire;
	assign accept   = s_tvalid && s_tready;

	assign ctl = '{accept: accept, fire: fire, op: s_tuser, unit: s_tdata[2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q  <= accept || (s1_valid_q && !fire);
			out_valid_q <= fire || (out_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
		if (fire) begin
			result_q <= result;
		end
	end

	purqp_core #(
		.NODES(NODES),
		.UNITS(UNITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.item  (item_s1),
		.result(result)
	);

	// Pack the result item.
	assign m_tvalid = out_valid_q;
	assign m_tuser  = result_q.status;
	assign m_tdata  = {6'b0, result_q.tag, result_q.write, result_q.count,
		result_q.list_address, result_q.offset, result_q.unit, result_q.node};

endmodule

FILE: verif/purqp_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the request queue pool, keeps its own copy of
// the pool state, works out the result of every accepted item and compares the
// results that come out in order, field by field.
module purqp_checker
	import purqp_pkg::*;
#(
	parameter int NODES = PURQP_NODES,
	parameter int UNITS = PURQP_UNITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [1:0]          s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	input  logic [2:0]          m_tuser,
	output int                  fail_count,
	output int                  pending
);

	localparam int IDX_W = $clog2(NODES);
	// A link with its top bit set points nowhere.
	localparam logic [IDX_W:0] LINK_NONE = {1'b1, {IDX_W{1'b0}}};

	// Shadow copy of the pool: chain links, free stack top, per-unit FIFO ends.
	logic [IDX_W:0] chain_link [NODES];
	logic [IDX_W:0] free_head;
	logic [IDX_W:0] unit_first [UNITS];
	logic [IDX_W:0] unit_last [UNITS];
	logic           node_held [NODES];
	slot_t          node_slot [NODES];

	result_t expected_results [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Pool state right after reset: every node stacked free, node 0 at the bottom.
	task automatic clear_pool();
		for (int i = 0; i < NODES; i++) begin
			chain_link[i] = (i == 0) ? LINK_NONE : (IDX_W + 1)'(i - 1);
			node_held[i] = 1'b0;
		end
		free_head = (IDX_W + 1)'(NODES - 1);
		for (int u = 0; u < UNITS; u++) begin
			unit_first[u] = LINK_NONE;
			unit_last[u] = LINK_NONE;
		end
	endtask

	function automatic item_t unpack_request(input logic [1:0] op,
			input logic [S_DATA_W-1:0] d);
		item_t it;
		it.op           = op;
		it.unit         = d[2:0];
		it.byte_offset  = d[66:3];
		it.list_address = d[130:67];
		it.sector_count = d[162:131];
		it.is_write     = d[163];
		it.request_tag  = d[195:164];
		it.node_index   = d[202:196];
		return it;
	endfunction

	function automatic result_t unpack_answer(input logic [2:0] st,
			input logic [M_DATA_W-1:0] d);
		result_t r;
		r.status       = status_t'(st);
		r.node         = d[6:0];
		r.unit         = d[8:7];
		r.offset       = d[72:9];
		r.list_address = d[136:73];
		r.count        = d[168:137];
		r.write        = d[169];
		r.tag          = d[201:170];
		return r;
	endfunction

	// Applies one operation to the shadow pool and returns the answer it gives.
	function automatic result_t pool_answer(input item_t it);
		result_t        r;
		logic [IDX_W:0] n;
		int             u;
		r = '0;
		r.status = ST_OK;
		u = int'(it.unit);
		case (it.op)
			OP_SUBMIT: begin
				if (it.unit >= UNITS) begin
					r.status = ST_BAD_UNIT;
				end else if (free_head[IDX_W]) begin
					r.status = ST_BUSY;
				end else begin
					n = free_head;
					free_head = chain_link[n[IDX_W-1:0]];
					node_slot[n[IDX_W-1:0]].offset  = it.byte_offset;
					node_slot[n[IDX_W-1:0]].address = it.list_address;
					node_slot[n[IDX_W-1:0]].count   = it.sector_count;
					node_slot[n[IDX_W-1:0]].tag     = it.request_tag;
					node_slot[n[IDX_W-1:0]].unit    = it.unit[1:0];
					node_slot[n[IDX_W-1:0]].write   = it.is_write;
					node_held[n[IDX_W-1:0]] = 1'b0;
					chain_link[n[IDX_W-1:0]] = LINK_NONE;
					// Append behind the current tail, or start the FIFO.
					if (!unit_last[u][IDX_W])
						chain_link[unit_last[u][IDX_W-1:0]] = n;
					else
						unit_first[u] = n;
					unit_last[u] = n;
					r.node = 7'(n[IDX_W-1:0]);
				end
			end
			OP_POP: begin
				if (it.unit >= UNITS) begin
					r.status = ST_BAD_UNIT;
				end else if (unit_first[u][IDX_W]) begin
					r.status = ST_EMPTY;
				end else begin
					n = unit_first[u];
					unit_first[u] = chain_link[n[IDX_W-1:0]];
					if (unit_first[u][IDX_W])
						unit_last[u] = LINK_NONE;
					chain_link[n[IDX_W-1:0]] = LINK_NONE;
					node_held[n[IDX_W-1:0]] = 1'b1;
					r.node         = 7'(n[IDX_W-1:0]);
					r.unit         = node_slot[n[IDX_W-1:0]].unit;
					r.offset       = node_slot[n[IDX_W-1:0]].offset;
					r.list_address = node_slot[n[IDX_W-1:0]].address;
					r.count        = node_slot[n[IDX_W-1:0]].count;
					r.write        = node_slot[n[IDX_W-1:0]].write;
					r.tag          = node_slot[n[IDX_W-1:0]].tag;
				end
			end
			OP_RELEASE: begin
				r.node = it.node_index;
				// Only a node that was popped and not yet given back may return.
				if (it.node_index >= NODES || !node_held[it.node_index]) begin
					r.status = ST_BAD_RELEASE;
				end else begin
					node_held[it.node_index] = 1'b0;
					chain_link[it.node_index] = free_head;
					free_head = (IDX_W + 1)'(it.node_index);
				end
			end
			default: begin
				// The spare opcode answers ok with every field zero.
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			if (fail_count < 10)
				$display("%t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
			fail_count++;
		end
	endtask

	// Predict on every accepted request item, compare on every accepted result item.
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		if (!arst_n) begin
			clear_pool();
			expected_results.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(pool_answer(unpack_request(s_tuser, s_tdata)));
			if (m_tvalid && m_tready) begin
				got = unpack_answer(m_tuser, m_tdata);
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("%t result with nothing expected: status %0d node %0d",
							$realtime, m_tuser, got.node);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("status", 64'(want.status), 64'(got.status));
					compare_field("out_node", 64'(want.node), 64'(got.node));
					compare_field("out_unit", 64'(want.unit), 64'(got.unit));
					compare_field("out_offset", want.offset, got.offset);
					compare_field("out_list_address", want.list_address, got.list_address);
					compare_field("out_count", 64'(want.count), 64'(got.count));
					compare_field("out_write", 64'(want.write), 64'(got.write));
					compare_field("out_tag", 64'(want.tag), 64'(got.tag));
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

FILE: verif/per_unit_request_queue_pool_top_tb.sv
`timescale 1ns / 1ps

module per_unit_request_queue_pool_top_tb;
	import purqp_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 250;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [1:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [2:0]          m_tuser;
	int                  fail_count;
	int                  pending;
	int                  cycles = 0;

	// While set, neither side idles.
	logic                calm = 1'b0;
	// Operations in flight, and nodes that pops handed out, for aiming releases.
	logic [1:0]          issued_ops [$];
	logic [6:0]          held_nodes [$];

	per_unit_request_queue_pool_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	purqp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up if the run hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	// Mostly random values, with the all-zero and all-one extremes mixed in.
	function automatic logic [63:0] wide_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Presents one item after a random gap and returns once it is taken.
	task automatic send_item(input logic [1:0] op, input logic [2:0] unit,
			input logic [63:0] off, input logic [63:0] addr, input logic [31:0] cnt,
			input logic wr, input logic [31:0] tag, input logic [6:0] node);
		int   gap;
		logic taken;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'b0, node, tag, wr, cnt, addr, off, unit};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		issued_ops.push_back(op);
	endtask

	// An item whose payload the operation does not use carries random noise.
	task automatic send_control(input logic [1:0] op, input logic [2:0] unit,
			input logic [6:0] node);
		send_item(op, unit, wide_value(), wide_value(), 32'(wide_value()), 1'($urandom()),
			32'(wide_value()), node);
	endtask

	// One random item from the given operation mix; releases mostly aim at held nodes.
	task automatic send_random(input int submit_pct, input int pop_pct,
			input int release_pct);
		int         pick;
		int         k;
		logic [1:0] op;
		logic [2:0] unit;
		logic [6:0] node;
		pick = $urandom_range(0, 99);
		if (pick < submit_pct)
			op = OP_SUBMIT;
		else if (pick < submit_pct + pop_pct)
			op = OP_POP;
		else if (pick < submit_pct + pop_pct + release_pct)
			op = OP_RELEASE;
		else
			op = OP_SPARE;
		if ($urandom_range(0, 9) != 0)
			unit = 3'($urandom_range(0, PURQP_UNITS - 1));
		else
			unit = 3'($urandom_range(PURQP_UNITS, 7));
		node = 7'($urandom_range(0, 127));
		if (op == OP_RELEASE && held_nodes.size() > 0 && $urandom_range(0, 4) != 0) begin
			k = $urandom_range(0, held_nodes.size() - 1);
			node = held_nodes[k];
			held_nodes.delete(k);
		end
		send_control(op, unit, node);
	endtask

	// Result side: random stalls, and note which nodes pops hand out.
	initial begin : result_sink
		int         gap;
		logic       seen;
		logic [6:0] got_node;
		logic [2:0] got_status;
		logic [1:0] done_op;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				seen = m_tvalid;
				got_node = m_tdata[6:0];
				got_status = m_tuser;
				@(posedge clk);
			end while (!seen);
			if (issued_ops.size() > 0) begin
				done_op = issued_ops.pop_front();
				if (done_op == OP_POP && got_status == ST_OK)
					held_nodes.push_back(got_node);
			end
		end
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes: first submit takes node 127, the second node 126.
		send_item(OP_SUBMIT, 3'd0, '1, '1, '1, 1'b1, '1, 7'd0);
		send_item(OP_SUBMIT, 3'd3, '0, '0, '0, 1'b0, '0, '1);
		send_item(OP_SUBMIT, 3'd0, wide_value(), wide_value(), 32'(wide_value()), 1'b1,
			32'(wide_value()), 7'd0);
		// Unit numbers out of range on submit and pop, and a pop of the empty unit 1.
		send_control(OP_SUBMIT, 3'(PURQP_UNITS), 7'd0);
		send_control(OP_SUBMIT, 3'd7, 7'd0);
		send_control(OP_POP, 3'd1, 7'd0);
		send_control(OP_POP, 3'd6, 7'd0);
		// Oldest first out of each FIFO.
		send_control(OP_POP, 3'd0, 7'd0);
		send_control(OP_POP, 3'd3, 7'd0);
		// A good release, then releases of a free node, a queued node and another free node.
		send_control(OP_RELEASE, 3'd0, 7'd127);
		send_control(OP_RELEASE, 3'd0, 7'd127);
		send_control(OP_RELEASE, 3'd0, 7'd125);
		send_control(OP_RELEASE, 3'd0, 7'd0);
		send_control(OP_SPARE, 3'd7, 7'd127);
		// Drain unit 0 down to empty, then give the nodes back.
		send_control(OP_POP, 3'd0, 7'd0);
		send_control(OP_POP, 3'd0, 7'd0);
		send_control(OP_RELEASE, 3'd0, 7'd126);
		send_control(OP_RELEASE, 3'd0, 7'd125);
		send_control(OP_SUBMIT, 3'd1, 7'd0);
		send_control(OP_SUBMIT, 3'd2, 7'd0);
		send_control(OP_SUBMIT, 3'd1, 7'd0);
		send_control(OP_POP, 3'd2, 7'd0);
		send_control(OP_POP, 3'd1, 7'd0);
		send_control(OP_POP, 3'd1, 7'd0);

		// Alternate filling phases, which run the pool dry, with draining ones.
		for (int phase = 0; phase < 8; phase++) begin
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase % 2 == 0)
					send_random(70, 15, 10);
				else
					send_random(10, 45, 40);
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: per_unit_request_queue_pool_top.f
rtl/purqp_pkg.sv
rtl/purqp_ram.sv
rtl/purqp_core.sv
rtl/per_unit_request_queue_pool_top.sv
verif/purqp_checker.sv
verif/per_unit_request_queue_pool_top_tb.sv
